[hdl/cffa_pkg.sv]
// ----------------------------------------------------------------------------
// cffa_pkg
// Shared constants and types of the chunked first-fit allocator.
// ----------------------------------------------------------------------------
package cffa_pkg;

    // Field widths of the request and response channels.
    localparam int KIND_W   = 1;
    localparam int SIZE_W   = 8;
    localparam int ADDR_W   = 9;
    localparam int STATUS_W = 2;

    // Default geometry.
    localparam int DEF_CHUNK_UNITS = 128;
    localparam int DEF_NUM_CHUNKS  = 4;

    // Units examined per scan cycle.
    localparam int SEG_UNITS = 8;

    // Widest run counter and offset over the supported geometry.
    localparam int RUN_W_MAX = 11;
    localparam int OFF_W_MAX = 10;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Outcome of one scan step over a segment of the occupancy row.
    typedef struct packed {
        logic                 found;
        logic [OFF_W_MAX-1:0] off;
        logic [RUN_W_MAX-1:0] run;
    } scan_res_t;

endpackage

[hdl/cffa_req_if.sv]
// ----------------------------------------------------------------------------
// cffa_req_if
// Request channel: allocate or free, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cffa_req_if;
    import cffa_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output kind, output request_size, output address,
                    input ready);
    modport sink   (input valid, input kind, input request_size, input address,
                    output ready);
endinterface

[hdl/cffa_rsp_if.sv]
// ----------------------------------------------------------------------------
// cffa_rsp_if
// Response channel: status and granted address, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cffa_rsp_if;
    import cffa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;

    modport source (output valid, output status, output granted_address, input ready);
    modport sink   (input valid, input status, input granted_address, output ready);
endinterface

[hdl/cffa_seg_scan.sv]
// ----------------------------------------------------------------------------
// cffa_seg_scan
// Free-run counter over one segment of an occupancy row; reports the first
// place where the run reaches the requested size.
// ----------------------------------------------------------------------------
module cffa_seg_scan (
    input  logic [cffa_pkg::SEG_UNITS-1:0] seg_bits,
    input  logic [cffa_pkg::RUN_W_MAX-1:0] run_in,
    input  logic [cffa_pkg::SIZE_W-1:0]    size,
    input  logic [cffa_pkg::OFF_W_MAX-1:0] base,
    output cffa_pkg::scan_res_t            res
);
    import cffa_pkg::*;

    // Walk the segment unit by unit; a used unit restarts the run.
    always_comb
    begin
        logic [RUN_W_MAX-1:0] run;
        logic                 found;
        logic [31:0]          off;
        run   = run_in;
        found = 1'b0;
        off   = '0;
        for (int j = 0; j < SEG_UNITS; j++)
        begin
            if (!found)
            begin
                if (seg_bits[j])
                begin
                    run = '0;
                end
                else
                begin
                    run = run + 1'b1;
                    if (run == RUN_W_MAX'(size))
                    begin
                        found = 1'b1;
                        off   = 32'(base) + 32'(j) + 32'd1 - 32'(size);
                    end
                end
            end
        end
        res.found = found;
        res.off   = off[OFF_W_MAX-1:0];
        res.run   = run;
    end
endmodule

[hdl/chunked_first_fit_allocator_core.sv]
// ----------------------------------------------------------------------------
// chunked_first_fit_allocator_core
// First-fit allocator over equal chunks, with occupancy and extent-length
// memories.
// ----------------------------------------------------------------------------
// After reset the block clears its memories, walking every entry of the
// extent-length memory, and takes no request in that time. One request is
// handled at a time. A free reads the occupancy row and the extent length,
// then clears the extent in both. An allocate searches each active chunk,
// newest first, with one row read and a scan that walks the occupancy row
// eight units a cycle, a run of free units carrying over between segments.
// Opening a new chunk adds a row read before the claim. The response sits in
// an output register, so the next request is taken while an earlier response
// still waits. CHUNK_UNITS must be a power of two.
module chunked_first_fit_allocator_core #(
    parameter int CHUNK_UNITS = cffa_pkg::DEF_CHUNK_UNITS,
    parameter int NUM_CHUNKS  = cffa_pkg::DEF_NUM_CHUNKS
) (
    input  logic       clk,
    input  logic       rst_n,
    cffa_req_if.sink   req,
    cffa_rsp_if.source rsp
);
    import cffa_pkg::*;

    localparam int TOTAL = CHUNK_UNITS * NUM_CHUNKS;
    localparam int A_W   = $clog2(TOTAL);
    localparam int OFF_W = $clog2(CHUNK_UNITS);
    localparam int CH_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int ACT_W = $clog2(NUM_CHUNKS + 1);
    localparam int LEN_W = $clog2(((CHUNK_UNITS > 255) ? 255 : CHUNK_UNITS) + 1);
    localparam int NSEG  = (CHUNK_UNITS + SEG_UNITS - 1) / SEG_UNITS;
    localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_RDC   = 4'd4;
    localparam logic [3:0] S_CLAIM = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_RESP  = 4'd8;

    // Memories.
    logic [CHUNK_UNITS-1:0] occ_mem [NUM_CHUNKS];
    logic [LEN_W-1:0]       len_mem [TOTAL];

    logic                   occ_re, occ_we, len_re, len_we;
    logic [CH_W-1:0]        occ_raddr, occ_waddr;
    logic [CHUNK_UNITS-1:0] occ_wdata, occ_rdata;
    logic [A_W-1:0]         len_raddr, len_waddr;
    logic [LEN_W-1:0]       len_wdata, len_rdata;

    // Control and payload registers.
    logic [3:0]          state_reg, state_next;
    logic [A_W-1:0]      clr_reg, clr_next;
    logic [ACT_W-1:0]    active_reg, active_next;
    logic [CH_W-1:0]     chunk_reg, chunk_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [A_W-1:0]      faddr_reg, faddr_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic [RUN_W_MAX-1:0] run_reg, run_next;
    logic                open_reg, open_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_granted_reg, res_granted_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_granted_reg, out_granted_next;

    logic                   req_fire;
    logic [SEG_UNITS-1:0]   seg_bits;
    scan_res_t              scan;
    logic [CHUNK_UNITS-1:0] mask;
    logic [31:0]            mask_off, mask_len;
    logic [31:0]            full_addr, in_addr;

    // Synchronous memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        if (occ_re)
        begin
            occ_rdata <= occ_mem[occ_raddr];
        end
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_re)
        begin
            len_rdata <= len_mem[len_raddr];
        end
    end

    // Pick the current eight units out of the row; units past the chunk count as used.
    always_comb
    begin
        int idx;
        for (int j = 0; j < SEG_UNITS; j++)
        begin
            idx = int'(seg_reg) * SEG_UNITS + j;
            seg_bits[j] = (idx < CHUNK_UNITS) ? occ_rdata[idx[OFF_W-1:0]] : 1'b1;
        end
    end

    cffa_seg_scan u_scan (
        .seg_bits (seg_bits),
        .run_in   (run_reg),
        .size     (size_reg),
        .base     (OFF_W_MAX'(32'(seg_reg) * SEG_UNITS)),
        .res      (scan)
    );

    // Extent mask for claim and release.
    always_comb
    begin
        for (int i = 0; i < CHUNK_UNITS; i++)
        begin
            mask[i] = (32'(i) >= mask_off) && (32'(i) < mask_off + mask_len);
        end
    end

    assign full_addr = 32'(chunk_reg) * CHUNK_UNITS + 32'(off_reg);
    assign in_addr   = 32'(req.address);
    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_address = out_granted_reg;

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        active_next      = active_reg;
        chunk_next       = chunk_reg;
        off_next         = off_reg;
        size_next        = size_reg;
        faddr_next       = faddr_reg;
        seg_next         = seg_reg;
        run_next         = run_reg;
        open_next        = open_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;

        occ_re    = 1'b0;
        occ_raddr = chunk_reg;
        occ_we    = 1'b0;
        occ_waddr = chunk_reg;
        occ_wdata = '0;
        len_re    = 1'b0;
        len_raddr = faddr_reg;
        len_we    = 1'b0;
        len_waddr = full_addr[A_W-1:0];
        len_wdata = LEN_W'(size_reg);
        mask_off  = 32'(off_reg);
        mask_len  = 32'(size_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                len_we    = 1'b1;
                len_waddr = clr_reg;
                len_wdata = '0;
                occ_we    = (32'(clr_reg) < NUM_CHUNKS);
                occ_waddr = clr_reg[CH_W-1:0];
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == TOTAL - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_granted_next = '0;
                    size_next        = req.request_size;
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (req.request_size == '0 ||
                            32'(req.request_size) > CHUNK_UNITS)
                        begin
                            res_status_next = ST_BAD_SIZE;
                            state_next      = S_RESP;
                        end
                        else if (active_reg == '0)
                        begin
                            chunk_next = '0;
                            off_next   = '0;
                            open_next  = 1'b1;
                            state_next = S_RDC;
                        end
                        else
                        begin
                            chunk_next = CH_W'(active_reg - 1'b1);
                            seg_next   = '0;
                            run_next   = '0;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        if (in_addr >= TOTAL)
                        begin
                            res_status_next = ST_NOT_FOUND;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            chunk_next = CH_W'(in_addr / CHUNK_UNITS);
                            off_next   = OFF_W'(in_addr % CHUNK_UNITS);
                            faddr_next = in_addr[A_W-1:0];
                            state_next = S_FRD;
                        end
                    end
                end
            end
            S_RD:
            begin
                occ_re     = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan.found)
                begin
                    off_next   = OFF_W'(scan.off);
                    open_next  = 1'b0;
                    state_next = S_CLAIM;
                end
                else if (32'(seg_reg) == NSEG - 1)
                begin
                    if (chunk_reg == '0)
                    begin
                        if (32'(active_reg) < NUM_CHUNKS)
                        begin
                            chunk_next = active_reg[CH_W-1:0];
                            off_next   = '0;
                            open_next  = 1'b1;
                            state_next = S_RDC;
                        end
                        else
                        begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_RESP;
                        end
                    end
                    else
                    begin
                        chunk_next = chunk_reg - 1'b1;
                        seg_next   = '0;
                        run_next   = '0;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    seg_next = seg_reg + 1'b1;
                    run_next = scan.run;
                end
            end
            S_RDC:
            begin
                occ_re     = 1'b1;
                state_next = S_CLAIM;
            end
            S_CLAIM:
            begin
                occ_we           = 1'b1;
                occ_wdata        = occ_rdata | mask;
                len_we           = 1'b1;
                res_status_next  = ST_OK;
                res_granted_next = full_addr[ADDR_W-1:0];
                if (open_reg)
                begin
                    active_next = active_reg + 1'b1;
                end
                state_next = S_RESP;
            end
            S_FRD:
            begin
                occ_re     = 1'b1;
                len_re     = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                mask_len = 32'(len_rdata);
                if (len_rdata == '0)
                begin
                    res_status_next = ST_NOT_FOUND;
                end
                else
                begin
                    occ_we          = 1'b1;
                    occ_wdata       = occ_rdata & ~mask;
                    len_we          = 1'b1;
                    len_waddr       = faddr_reg;
                    len_wdata       = '0;
                    res_status_next = ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_granted_next = res_granted_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chunk_reg       <= chunk_next;
        off_reg         <= off_next;
        size_reg        <= size_next;
        faddr_reg       <= faddr_next;
        seg_reg         <= seg_next;
        run_reg         <= run_next;
        open_reg        <= open_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
    end

    // A new response only appears when the sequencer hands one over.
    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response appeared outside the response state");

    // No request is taken while the memories are being cleared.
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request accepted during clearing pass");

    // The count of open chunks never exceeds the chunk count.
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_reg) <= NUM_CHUNKS)
        else $error("active chunk count out of range");

    // Opening a chunk advances the count by exactly one.
    a_open_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAIM && open_reg) |=> (active_reg == $past(active_reg) + 1'b1))
        else $error("chunk open did not advance the count");
endmodule
